### rtl/lgs_pkg.sv
// shared types, constants and the next-generation row function for the life grid block
package lgs_pkg;

	localparam int GRID_ROWS = 48;
	localparam int GRID_COLS = 64;
	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam int CNT_W = $clog2(GRID_ROWS + 2);

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_STEP = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// three-cell window masks, bit 0 is the left neighbor
	localparam logic [2:0] WIN_MID = 3'h2;
	localparam logic [2:0] WIN_SIDES = 3'h5;

	typedef logic [GRID_COLS-1:0] row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_ISSUE,
		ST_RD_DONE,
		ST_GEN,
		ST_GEN_DONE
	} state_t;

	typedef enum logic [1:0] {
		RES_IMM,
		RES_READ,
		RES_GEN
	} res_sel_t;

	typedef struct packed {
		logic     cap;
		logic     wr_in;
		logic     rd_item;
		logic     gen_clear;
		logic     gen_run;
		logic     load;
		res_sel_t res_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic       slot_free;
		logic [1:0] in_cmd;
		logic       idx_err;
		logic       gen_last;
	} dp_stat_t;

	// columns j-1, j, j+1 with dead cells past both edges
	function automatic logic [2:0] window3(input row_t r, input int j);
		logic [GRID_COLS+1:0] padded;
		padded = {1'b0, r, 1'b0};
		return padded[j +: 3];
	endfunction

	function automatic logic [1:0] count3(input logic [2:0] w);
		return {1'b0, w[0]} + {1'b0, w[1]} + {1'b0, w[2]};
	endfunction

	// B3/S23 applied to every column of one row
	function automatic row_t next_row(input row_t above, input row_t here, input row_t below);
		row_t       res;
		logic [2:0] wh;
		logic [3:0] n;
		logic       alive;
		res = '0;
		for (int j = 0; j < GRID_COLS; j++) begin
			wh = window3(here, j);
			n = 4'(count3(window3(above, j))) + 4'(count3(window3(below, j)))
				+ 4'(count3(wh & WIN_SIDES));
			alive = |(wh & WIN_MID);
			res[j] = (n == 4'd3) || (alive && (n == 4'd2));
		end
		return res;
	endfunction

endpackage

### rtl/lgs_ctrl.sv
// controller state machine for the life grid block
module lgs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lgs_pkg::dp_stat_t stat,
	output lgs_pkg::dp_cmd_t  cmd
);

	lgs_pkg::state_t state_q;
	lgs_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.res_sel = lgs_pkg::RES_IMM;
		case (state_q)
			lgs_pkg::ST_IDLE: begin
				in_ready = stat.slot_free;
				if (in_valid && stat.slot_free) begin
					cmd.cap = 1'b1;
					case (stat.in_cmd)
						lgs_pkg::CMD_READ: begin
							if (stat.idx_err) begin
								cmd.load = 1'b1;
							end else begin
								state_nxt = lgs_pkg::ST_RD_ISSUE;
							end
						end
						lgs_pkg::CMD_STEP: begin
							cmd.gen_clear = 1'b1;
							state_nxt = lgs_pkg::ST_GEN;
						end
						lgs_pkg::CMD_WRITE: begin
							cmd.wr_in = !stat.idx_err;
							cmd.load = 1'b1;
						end
						default: begin
							cmd.load = 1'b1;
						end
					endcase
				end
			end
			lgs_pkg::ST_RD_ISSUE: begin
				cmd.rd_item = 1'b1;
				state_nxt = lgs_pkg::ST_RD_DONE;
			end
			lgs_pkg::ST_RD_DONE: begin
				// keep reading the same row so the data stays fresh while stalled
				cmd.rd_item = 1'b1;
				cmd.res_sel = lgs_pkg::RES_READ;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					state_nxt = lgs_pkg::ST_IDLE;
				end
			end
			lgs_pkg::ST_GEN: begin
				cmd.gen_run = 1'b1;
				if (stat.gen_last) begin
					state_nxt = lgs_pkg::ST_GEN_DONE;
				end
			end
			lgs_pkg::ST_GEN_DONE: begin
				cmd.res_sel = lgs_pkg::RES_GEN;
				if (stat.slot_free) begin
					cmd.load = 1'b1;
					state_nxt = lgs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lgs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/lgs_dp.sv
// datapath for the life grid block: row memory, row window, rule logic, result register
module lgs_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  lgs_pkg::dp_cmd_t  cmd,
	output lgs_pkg::dp_stat_t stat,
	input  logic [1:0]        command,
	input  logic [5:0]        row_index,
	input  logic [63:0]       row_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       row_data,
	output logic [1:0]        done_command,
	output logic              index_error
);

	lgs_pkg::row_t mem [lgs_pkg::GRID_ROWS];
	logic [lgs_pkg::GRID_ROWS-1:0] row_ok_q;

	logic [lgs_pkg::ROW_W-1:0] idx_q;
	logic [lgs_pkg::CNT_W-1:0] cnt_q;
	lgs_pkg::row_t above_q;
	lgs_pkg::row_t here_q;
	lgs_pkg::row_t rd_data_s1;
	logic          rd_ok_s1;

	logic        out_valid_q;
	logic [63:0] row_data_q;
	logic [1:0]  done_command_q;
	logic        index_error_q;

	logic                      idx_err;
	logic [lgs_pkg::ROW_W-1:0] in_addr;
	logic                      gen_rd;
	logic                      gen_wr;
	logic                      rd_en;
	logic [lgs_pkg::ROW_W-1:0] rd_addr;
	logic                      wr_en;
	logic [lgs_pkg::ROW_W-1:0] wr_addr;
	lgs_pkg::row_t             wr_data;
	lgs_pkg::row_t             below;
	lgs_pkg::row_t             fresh;
	logic                      slot_free;

	assign idx_err = int'(row_index) >= lgs_pkg::GRID_ROWS;
	assign in_addr = lgs_pkg::ROW_W'(row_index);

	assign gen_rd = cmd.gen_run && (cnt_q < lgs_pkg::CNT_W'(lgs_pkg::GRID_ROWS));
	assign gen_wr = cmd.gen_run && (cnt_q >= lgs_pkg::CNT_W'(2));

	assign rd_en = cmd.rd_item || gen_rd;
	assign rd_addr = cmd.rd_item ? idx_q : lgs_pkg::ROW_W'(cnt_q);

	// never-written rows and the row past the bottom edge read as dead
	assign below = rd_ok_s1 ? rd_data_s1 : '0;
	assign fresh = lgs_pkg::next_row(above_q, here_q, below);

	assign wr_en = cmd.wr_in || gen_wr;
	assign wr_addr = cmd.wr_in ? in_addr : lgs_pkg::ROW_W'(cnt_q - lgs_pkg::CNT_W'(2));
	assign wr_data = cmd.wr_in ? row_value[lgs_pkg::GRID_COLS-1:0] : fresh;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		stat.slot_free = slot_free;
		stat.in_cmd = command;
		stat.idx_err = idx_err;
		stat.gen_last = cnt_q == lgs_pkg::CNT_W'(lgs_pkg::GRID_ROWS + 1);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			rd_ok_s1 <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				row_ok_q[wr_addr] <= 1'b1;
			end
			rd_ok_s1 <= rd_en && row_ok_q[rd_addr];
			if (cmd.gen_clear) begin
				cnt_q <= '0;
			end else if (cmd.gen_run) begin
				cnt_q <= cnt_q + lgs_pkg::CNT_W'(1);
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// row window slides down one row per step
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			idx_q <= in_addr;
		end
		if (cmd.gen_clear) begin
			above_q <= '0;
			here_q <= '0;
		end else if (cmd.gen_run && (cnt_q >= lgs_pkg::CNT_W'(1))) begin
			above_q <= here_q;
			here_q <= below;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.res_sel)
				lgs_pkg::RES_READ: begin
					row_data_q <= 64'(below);
					done_command_q <= lgs_pkg::CMD_READ;
					index_error_q <= 1'b0;
				end
				lgs_pkg::RES_GEN: begin
					row_data_q <= '0;
					done_command_q <= lgs_pkg::CMD_STEP;
					index_error_q <= 1'b0;
				end
				default: begin
					row_data_q <= '0;
					done_command_q <= command;
					index_error_q <= idx_err
						&& ((command == lgs_pkg::CMD_WRITE) || (command == lgs_pkg::CMD_READ));
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign row_data = row_data_q;
	assign done_command = done_command_q;
	assign index_error = index_error_q;

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> slot_free)
		else $error("result loaded over a pending result");
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (int'(wr_addr) < lgs_pkg::GRID_ROWS))
		else $error("row write outside the grid");
	a_gen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gen_run |-> (int'(cnt_q) <= lgs_pkg::GRID_ROWS + 1))
		else $error("generation counter overran");
	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_in |-> !cmd.gen_run)
		else $error("row write during generation step");
`endif

endmodule

### rtl/life_grid_generation_step_top.sv
// top level of the life grid block: B3/S23 grid of rows by 64 columns
//
// one input channel (in_valid/in_ready) carries command, row_index, row_value;
// one output channel (out_valid/out_ready) returns row_data, done_command, index_error.
// every input transfer produces exactly one output transfer, in order.
// write row: the row is stored and the result is loaded into the output register
//   at the input transfer; back-to-back writes go at one per cycle while results are taken
// read row: the controller passes ST_RD_ISSUE then ST_RD_DONE before the result is
//   loaded (memory read port is registered); the next read waits until it is loaded
// generation step: the row memory is swept once through its single read port,
//   one row per cycle with a three-row window, then the result is loaded;
//   rows are written back in place right behind the reads
// out-of-range row index or unknown command: answered at once, grid untouched
// one command is in work at a time; in_ready is high only while the controller
// is idle and the output register is empty or being drained
// when the receiver stalls the result holds in the output register and the
// next command waits until it is taken
// reset clears per-row valid flags, so every row reads as dead right away;
// no clearing sweep is needed
module life_grid_generation_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [5:0]  row_index,
	input  logic [63:0] row_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] row_data,
	output logic [1:0]  done_command,
	output logic        index_error
);

	// command and status between the sequencer and the datapath
	lgs_pkg::dp_cmd_t  dp_cmd;
	lgs_pkg::dp_stat_t dp_stat;

	lgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// row memory, window registers, rule logic and output register
	lgs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.stat         (dp_stat),
		.command      (command),
		.row_index    (row_index),
		.row_value    (row_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_data     (row_data),
		.done_command (done_command),
		.index_error  (index_error)
	);

endmodule

### sim/life_grid_generation_step_top_tb.sv
// testbench for the life grid block: directed table then bursty random commands
module life_grid_generation_step_top_tb;

	// command code with no meaning, answered at once with nothing but the echo
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	localparam lgs_pkg::row_t FULL_ROW = '1;
	localparam int DIRECTED_ITEMS = 26;
	localparam int RANDOM_ITEMS = 550;
	// settle past the length of a full generation sweep
	localparam int SETTLE_CYCLES = lgs_pkg::GRID_ROWS + 20;
	// longest honest quiet stretch is a sweep plus a receiver stall; this is far beyond it
	localparam int WATCHDOG_LIMIT = 2000;

	// one answer as the output channel should deliver it
	typedef struct {
		lgs_pkg::row_t data;
		logic [1:0]    cmd;
		logic          err;
	} life_answer_t;

	// one row of the directed table; pinned rows carry an answer typed in by hand
	typedef struct {
		logic [1:0]    cmd;
		logic [5:0]    idx;
		lgs_pkg::row_t val;
		bit            pinned;
		lgs_pkg::row_t pin_data;
		logic          pin_err;
	} dir_row_t;

	// how the receiver throttles the output channel during one stretch
	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SPARSE,
		DRAIN_HOLD
	} drain_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = lgs_pkg::CMD_WRITE;
	logic [5:0]  row_index = '0;
	logic [63:0] row_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] row_data;
	logic [1:0]  done_command;
	logic        index_error;

	// shadow copy of the grid, updated at every accepted command
	lgs_pkg::row_t life_rows [lgs_pkg::GRID_ROWS];
	// answers owed by the block, oldest first
	life_answer_t pending_answers [$];
	int unsigned fault_count = 0;

	dir_row_t directed_stim [DIRECTED_ITEMS] = '{
		// fresh grid reads dead at both ends
		'{lgs_pkg::CMD_READ, 6'd0, '0, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_READ, 6'd47, '0, 1'b1, '0, 1'b0},
		// out-of-range rows flag an error and touch nothing
		'{lgs_pkg::CMD_WRITE, 6'd48, FULL_ROW, 1'b1, '0, 1'b1},
		'{lgs_pkg::CMD_READ, 6'd63, '0, 1'b1, '0, 1'b1},
		'{lgs_pkg::CMD_WRITE, 6'd63, '0, 1'b1, '0, 1'b1},
		// unknown command just echoes itself
		'{CMD_UNKNOWN, 6'd5, FULL_ROW, 1'b1, '0, 1'b0},
		// full-width and corner-bit rows at the grid edges
		'{lgs_pkg::CMD_WRITE, 6'd0, FULL_ROW, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_READ, 6'd0, '0, 1'b1, FULL_ROW, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd47, 64'h8000_0000_0000_0001, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_READ, 6'd47, '0, 1'b1, 64'h8000_0000_0000_0001, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd0, '0, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd47, '0, 1'b1, '0, 1'b0},
		// vertical blinker away from the grid edges
		'{lgs_pkg::CMD_WRITE, 6'd10, 64'h20, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd11, 64'h20, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd12, 64'h20, 1'b1, '0, 1'b0},
		// blinkers against the left and the right edge
		'{lgs_pkg::CMD_WRITE, 6'd20, 64'h1, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd21, 64'h1, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd22, 64'h1, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd30, 64'h8000_0000_0000_0000, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd31, 64'h8000_0000_0000_0000, 1'b1, '0, 1'b0},
		'{lgs_pkg::CMD_WRITE, 6'd32, 64'h8000_0000_0000_0000, 1'b1, '0, 1'b0},
		// generation step ignores index and value
		'{lgs_pkg::CMD_STEP, 6'd63, FULL_ROW, 1'b1, '0, 1'b0},
		// blinker turns horizontal
		'{lgs_pkg::CMD_READ, 6'd11, '0, 1'b1, 64'h70, 1'b0},
		'{lgs_pkg::CMD_READ, 6'd21, '0, 1'b0, '0, 1'b0},
		'{lgs_pkg::CMD_READ, 6'd31, '0, 1'b0, '0, 1'b0},
		'{lgs_pkg::CMD_STEP, 6'd0, '0, 1'b1, '0, 1'b0}
	};

	life_grid_generation_step_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.row_index    (row_index),
		.row_value    (row_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.row_data     (row_data),
		.done_command (done_command),
		.index_error  (index_error)
	);

	always #5 clk = ~clk;

	// one B3/S23 generation over the shadow grid; shifts line up the eight neighbors
	// of every column, with zeros shifted in past both side edges
	function automatic void advance_life_rows();
		lgs_pkg::row_t fresh [lgs_pkg::GRID_ROWS];
		lgs_pkg::row_t nb [8];
		lgs_pkg::row_t above;
		lgs_pkg::row_t below;
		lgs_pkg::row_t here;
		logic [3:0]    n;
		for (int i = 0; i < lgs_pkg::GRID_ROWS; i++) begin
			above = (i > 0) ? life_rows[i-1] : '0;
			below = (i < lgs_pkg::GRID_ROWS - 1) ? life_rows[i+1] : '0;
			here = life_rows[i];
			nb[0] = above;
			nb[1] = above << 1;
			nb[2] = above >> 1;
			nb[3] = below;
			nb[4] = below << 1;
			nb[5] = below >> 1;
			nb[6] = here << 1;
			nb[7] = here >> 1;
			for (int j = 0; j < lgs_pkg::GRID_COLS; j++) begin
				n = '0;
				for (int k = 0; k < 8; k++)
					n = n + 4'(nb[k][j]);
				fresh[i][j] = (n == 4'd3) || (here[j] && (n == 4'd2));
			end
		end
		for (int i = 0; i < lgs_pkg::GRID_ROWS; i++)
			life_rows[i] = fresh[i];
	endfunction

	// apply one command to the shadow grid and return the answer it earns
	function automatic life_answer_t apply_command(input logic [1:0] cmd,
			input logic [5:0] idx, input lgs_pkg::row_t val);
		life_answer_t ans;
		ans.data = '0;
		ans.cmd = cmd;
		ans.err = 1'b0;
		case (cmd)
			lgs_pkg::CMD_WRITE: begin
				if (idx >= lgs_pkg::GRID_ROWS)
					ans.err = 1'b1;
				else
					life_rows[idx] = val;
			end
			lgs_pkg::CMD_READ: begin
				if (idx >= lgs_pkg::GRID_ROWS)
					ans.err = 1'b1;
				else
					ans.data = life_rows[idx];
			end
			lgs_pkg::CMD_STEP: advance_life_rows();
			default: ;
		endcase
		return ans;
	endfunction

	// row contents with a spread of densities so that the grid stays alive
	function automatic lgs_pkg::row_t pattern_row();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return FULL_ROW;
			2: return {$urandom, $urandom};
			6: return lgs_pkg::row_t'(1) << $urandom_range(0, lgs_pkg::GRID_COLS - 1);
			7: return lgs_pkg::row_t'(7) << $urandom_range(0, lgs_pkg::GRID_COLS - 3);
			default: return {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	// present one command, hold it until the transfer, then book its answer;
	// valid is left high so a follow-on command does not bounce it
	task automatic send_item(input logic [1:0] cmd, input logic [5:0] idx,
			input lgs_pkg::row_t val, input bit pinned, input lgs_pkg::row_t pin_data,
			input logic pin_err);
		life_answer_t ans;
		in_valid <= 1'b1;
		command <= cmd;
		row_index <= idx;
		row_value <= val;
		do
			@(posedge clk);
		while (!in_ready);
		ans = apply_command(cmd, idx, val);
		if (pinned) begin
			ans.data = pin_data;
			ans.err = pin_err;
		end
		pending_answers.push_back(ans);
	endtask

	// hold the sender off until the block owes nothing
	task automatic wait_for_answers();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_answers.size() != 0);
	endtask

	// output side: every transfer must match the oldest owed answer field by field
	always @(posedge clk) begin
		life_answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result: row_data %h done_command %0d index_error %0d",
					$time, row_data, done_command, index_error);
				fault_count++;
			end else begin
				want = pending_answers.pop_front();
				if (row_data !== want.data) begin
					$display("%0t: row_data expected %h got %h", $time, want.data, row_data);
					fault_count++;
				end
				if (done_command !== want.cmd) begin
					$display("%0t: done_command expected %0d got %0d", $time, want.cmd,
						done_command);
					fault_count++;
				end
				if (index_error !== want.err) begin
					$display("%0t: index_error expected %0d got %0d", $time, want.err,
						index_error);
					fault_count++;
				end
			end
		end
	end

	// receiver: stretches of free flow, coin flips, sparse accepts and long holds
	initial begin
		drain_mode_t mode;
		int unsigned phase;
		phase = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			mode = drain_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(20, 120)) begin
				@(posedge clk);
				case (mode)
					DRAIN_FREE: out_ready <= 1'b1;
					DRAIN_COIN: out_ready <= 1'($urandom_range(0, 1));
					DRAIN_SPARSE: out_ready <= (phase % 4 == 0);
					DRAIN_HOLD: out_ready <= (phase % 32 >= 24);
					default: out_ready <= 1'b1;
				endcase
				phase++;
			end
		end
	end

	// watchdog: too long without any transfer means the block is stuck
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// sender: reset, directed table, then random commands in bursts
	initial begin
		int burst_left;
		int gap;
		int pick;
		logic [5:0] idx;
		burst_left = 0;
		foreach (life_rows[r])
			life_rows[r] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back
		for (int d = 0; d < DIRECTED_ITEMS; d++)
			send_item(directed_stim[d].cmd, directed_stim[d].idx, directed_stim[d].val,
				directed_stim[d].pinned, directed_stim[d].pin_data, directed_stim[d].pin_err);
		wait_for_answers();

		// random part: mostly well-formed grid traffic, some errors and noise
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 2)
				wait_for_answers();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				send_item(lgs_pkg::CMD_WRITE, 6'($urandom_range(0, lgs_pkg::GRID_ROWS - 1)),
					pattern_row(), 1'b0, '0, 1'b0);
			end else if (pick < 58) begin
				send_item(lgs_pkg::CMD_READ, 6'($urandom_range(0, lgs_pkg::GRID_ROWS - 1)),
					pattern_row(), 1'b0, '0, 1'b0);
			end else if (pick < 70) begin
				send_item(lgs_pkg::CMD_STEP, 6'($urandom_range(0, 63)), {$urandom, $urandom},
					1'b0, '0, 1'b0);
			end else if (pick < 80) begin
				// rows past the end of the grid
				send_item($urandom_range(0, 1) ? lgs_pkg::CMD_WRITE : lgs_pkg::CMD_READ,
					6'($urandom_range(lgs_pkg::GRID_ROWS, 63)), {$urandom, $urandom},
					1'b0, '0, 1'b0);
			end else if (pick < 85) begin
				send_item(CMD_UNKNOWN, 6'($urandom_range(0, 63)), {$urandom, $urandom},
					1'b0, '0, 1'b0);
			end else begin
				// top and bottom edge rows
				case ($urandom_range(0, 3))
					0: idx = 6'd0;
					1: idx = 6'd1;
					2: idx = 6'(lgs_pkg::GRID_ROWS - 2);
					default: idx = 6'(lgs_pkg::GRID_ROWS - 1);
				endcase
				send_item(lgs_pkg::CMD_WRITE, idx, pattern_row(), 1'b0, '0, 1'b0);
			end
		end

		// drain and give the block time to show any stray result
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_answers.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### files.f
rtl/lgs_pkg.sv
rtl/lgs_ctrl.sv
rtl/lgs_dp.sv
rtl/life_grid_generation_step_top.sv
sim/life_grid_generation_step_top_tb.sv
